FILE: src/ctw_pkg.sv
`timescale 1ns / 1ps

package ctw_pkg;

  // Screen geometry.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(CELLS);

  // Field widths.
  localparam int ACT_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int CELL_W  = CHAR_W + COLOR_W;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE      = 8'd10;
  localparam logic [CHAR_W-1:0]  SPACE_CODE        = 8'd32;
  localparam logic [COLOR_W-1:0] DEFAULT_COLOR_RST = 8'd15;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  // One input item.
  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [CHAR_W-1:0]  char_code;
    logic [COLOR_W-1:0] color;
    logic [ROW_W-1:0]   read_row;
    logic [COL_W-1:0]   read_col;
  } item_t;

  // Commands from the sequencer to the cursor.
  typedef struct packed {
    logic adv;   // advance by one cell, or to the next row with nl
    logic nl;
    logic home;  // back to cell 0
  } cur_cmd_t;

  // Cursor status seen by the sequencer.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last_row;
    logic             last_col;
  } cur_stat_t;

  // Linear cell address of a row and column.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    return a;
  endfunction

endpackage

FILE: src/ctw_ram.sv
`timescale 1ns / 1ps

module ctw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one read port with registered data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: src/ctw_cursor.sv
`timescale 1ns / 1ps

module ctw_cursor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctw_pkg::cur_cmd_t  cmd_i,
  output ctw_pkg::cur_stat_t stat_o
);

  logic [ctw_pkg::ROW_W-1:0] row_q, row_d;
  logic [ctw_pkg::COL_W-1:0] col_q, col_d;
  logic                      last_row, last_col;

  assign last_row = (row_q == ctw_pkg::ROW_W'(ctw_pkg::ROWS - 1));
  assign last_col = (col_q == ctw_pkg::COL_W'(ctw_pkg::COLUMNS - 1));

  // Next position. Running off the bottom row stays on the bottom row,
  // since the store scrolls up underneath.
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cmd_i.home) begin
      row_d = '0;
      col_d = '0;
    end else if (cmd_i.adv) begin
      if (cmd_i.nl || last_col) begin
        col_d = '0;
        if (!last_row) begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  assign stat_o.row      = row_q;
  assign stat_o.col      = col_q;
  assign stat_o.last_row = last_row;
  assign stat_o.last_col = last_col;

  // The cursor never leaves the screen.
  a_cursor_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q < ctw_pkg::ROW_W'(ctw_pkg::ROWS)) && (col_q < ctw_pkg::COL_W'(ctw_pkg::COLUMNS)))
    else $error("cursor off screen");

endmodule

FILE: src/ctw_ctrl.sv
`timescale 1ns / 1ps

module ctw_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  ctw_pkg::item_t              in_item_i,
  output logic                        in_ready_o,
  input  logic [ctw_pkg::COLOR_W-1:0] default_color_i,
  input  ctw_pkg::cur_stat_t          cur_stat_i,
  output ctw_pkg::cur_cmd_t           cur_cmd_o,
  output logic                        ram_we_o,
  output logic [ctw_pkg::ADDR_W-1:0]  ram_waddr_o,
  output logic [ctw_pkg::CELL_W-1:0]  ram_wdata_o,
  output logic                        ram_re_o,
  output logic [ctw_pkg::ADDR_W-1:0]  ram_raddr_o,
  input  logic [ctw_pkg::CELL_W-1:0]  ram_rdata_i,
  input  logic                        out_free_i,
  output logic                        res_load_o,
  output logic [ctw_pkg::CELL_W-1:0]  res_cell_o
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_CLEAR  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  localparam logic [ctw_pkg::ADDR_W-1:0] LAST_CELL = ctw_pkg::ADDR_W'(ctw_pkg::CELLS - 1);
  localparam logic [ctw_pkg::ADDR_W-1:0] MOVE_END  =
    ctw_pkg::ADDR_W'(ctw_pkg::CELLS - ctw_pkg::COLUMNS);

  logic [2:0]                  state_q, state_d;
  logic [ctw_pkg::ADDR_W-1:0]  cnt_q, cnt_d;
  logic [ctw_pkg::CELL_W-1:0]  cell_q, cell_d;

  // Registered write stage: data comes either from the register or from
  // the RAM read issued in the previous cycle (scroll moves).
  logic                        wr_en_q, wr_en_d;
  logic                        wr_ram_q, wr_ram_d;
  logic [ctw_pkg::ADDR_W-1:0]  wr_addr_q, wr_addr_d;
  logic [ctw_pkg::CELL_W-1:0]  wr_data_q, wr_data_d;

  logic                        accept;
  logic                        is_nl;
  logic                        read_hit;
  logic [ctw_pkg::COLOR_W-1:0] attr;

  // A pending write holds off a new item so a read never meets it.
  assign in_ready_o = (state_q == S_IDLE) && !wr_en_q;
  assign accept     = in_valid_i && in_ready_o;

  assign is_nl    = (in_item_i.char_code == ctw_pkg::NEWLINE_CODE);
  assign read_hit = (in_item_i.read_row < ctw_pkg::ROW_W'(ctw_pkg::ROWS)) &&
                    (in_item_i.read_col < ctw_pkg::COL_W'(ctw_pkg::COLUMNS));
  assign attr     = (in_item_i.color == '0) ? default_color_i : in_item_i.color;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cell_d      = cell_q;
    wr_en_d     = 1'b0;
    wr_ram_d    = 1'b0;
    wr_addr_d   = wr_addr_q;
    wr_data_d   = wr_data_q;
    cur_cmd_o   = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = cnt_q + ctw_pkg::ADDR_W'(ctw_pkg::COLUMNS);
    res_load_o  = 1'b0;
    unique case (state_q)
      S_INIT: begin
        wr_en_d   = 1'b1;
        wr_addr_d = cnt_q;
        wr_data_d = '0;
        if (cnt_q == LAST_CELL) begin
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cell_d  = '0;
          state_d = S_DONE;
          unique case (in_item_i.action)
            ctw_pkg::ACT_PUT: begin
              cur_cmd_o.adv = 1'b1;
              cur_cmd_o.nl  = is_nl;
              if (!is_nl) begin
                wr_en_d   = 1'b1;
                wr_addr_d = ctw_pkg::cell_addr(cur_stat_i.row, cur_stat_i.col);
                wr_data_d = {attr, in_item_i.char_code};
              end
              if (cur_stat_i.last_row && (is_nl || cur_stat_i.last_col)) begin
                state_d = S_SCROLL;
                cnt_d   = '0;
              end
            end
            ctw_pkg::ACT_CLEAR: begin
              cur_cmd_o.home = 1'b1;
              state_d        = S_CLEAR;
              cnt_d          = '0;
            end
            ctw_pkg::ACT_READ: begin
              if (read_hit) begin
                ram_re_o    = 1'b1;
                ram_raddr_o = ctw_pkg::cell_addr(in_item_i.read_row, in_item_i.read_col);
                state_d     = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        cell_d  = ram_rdata_i;
        state_d = S_DONE;
      end
      S_SCROLL: begin
        // Read the cell one row down, write it here next cycle; the
        // bottom row is filled with zeros.
        ram_re_o  = (cnt_q < MOVE_END);
        wr_en_d   = 1'b1;
        wr_ram_d  = (cnt_q < MOVE_END);
        wr_addr_d = cnt_q;
        wr_data_d = '0;
        if (cnt_q == LAST_CELL) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_CLEAR: begin
        wr_en_d   = 1'b1;
        wr_addr_d = cnt_q;
        wr_data_d = {default_color_i, ctw_pkg::SPACE_CODE};
        if (cnt_q == LAST_CELL) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          res_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      cnt_q   <= '0;
      wr_en_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      wr_en_q <= wr_en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q    <= cell_d;
    wr_ram_q  <= wr_ram_d;
    wr_addr_q <= wr_addr_d;
    wr_data_q <= wr_data_d;
  end

  assign ram_we_o    = wr_en_q;
  assign ram_waddr_o = wr_addr_q;
  assign ram_wdata_o = wr_ram_q ? ram_rdata_i : wr_data_q;
  assign res_cell_o  = cell_q;

  // The RAM never reads the cell it is writing in the same cycle.
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_re_o && wr_en_q) |-> (ram_raddr_o != wr_addr_q))
    else $error("read and write of the same cell in one cycle");

  // A move in the scroll sweep always has its read from the cycle before.
  a_move_has_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCROLL && cnt_q < MOVE_END) |=> (wr_en_q && wr_ram_q))
    else $error("scroll move without its write");

  // An accepted item always leaves the idle state.
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("accepted item left no trace");

  // A result is loaded only when the output register can take it.
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load_o |-> out_free_i)
    else $error("result loaded over a waiting result");

endmodule

FILE: src/text_console_writer_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  s_axis_tdata[31:0], one item
// m_axis    out        m_axis_tvalid / m_axis_tready  m_axis_tdata[31:0], one result
// cfg       in         cfg_valid_i / cfg_ready_o     cfg_data_i[7:0], default color
//
// A put, a newline, an out-of-range read or an unused action goes straight to the
// final step; a read of a cell first passes through a step for the RAM read.
// A put that runs off the last cell, a newline on the bottom row, and a clear
// sweep the cell RAM one cell per cycle.
// After reset the RAM is zeroed, and s_axis_tready rises once the last zero
// write has gone out. Configuration writes are taken at any time.
// The result sits in an output register; a stalled m_axis holds the block in its
// final step, and the next item is taken as soon as the result has moved on.

module text_console_writer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Fields from bit 0: action[1:0], char_code[9:2], color[17:10],
  // read_row[22:18], read_col[29:23], zero[31:30].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  // Fields from bit 0: cursor_row[4:0], cursor_col[11:5], cell_char[19:12],
  // cell_color[27:20], zero[31:28].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  ctw_pkg::item_t                item;
  ctw_pkg::cur_cmd_t             cur_cmd;
  ctw_pkg::cur_stat_t            cur_stat;
  logic [ctw_pkg::COLOR_W-1:0]   default_color_q;
  logic                          ram_we, ram_re;
  logic [ctw_pkg::ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [ctw_pkg::CELL_W-1:0]    ram_wdata, ram_rdata;
  logic                          out_free, res_load;
  logic [ctw_pkg::CELL_W-1:0]    res_cell;
  logic                          out_valid_q;
  logic [ctw_pkg::ROW_W-1:0]     out_row_q;
  logic [ctw_pkg::COL_W-1:0]     out_col_q;
  logic [ctw_pkg::CELL_W-1:0]    out_cell_q;

  // Unpack the input item.
  assign item.action    = s_axis_tdata[1:0];
  assign item.char_code = s_axis_tdata[9:2];
  assign item.color     = s_axis_tdata[17:10];
  assign item.read_row  = s_axis_tdata[22:18];
  assign item.read_col  = s_axis_tdata[29:23];

  // Default color register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_color_q <= ctw_pkg::DEFAULT_COLOR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      default_color_q <= cfg_data_i;
    end
  end

  ctw_ram #(
    .WIDTH(ctw_pkg::CELL_W),
    .DEPTH(ctw_pkg::CELLS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  ctw_cursor u_cursor (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cur_cmd),
    .stat_o(cur_stat)
  );

  ctw_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_item_i      (item),
    .in_ready_o     (s_axis_tready),
    .default_color_i(default_color_q),
    .cur_stat_i     (cur_stat),
    .cur_cmd_o      (cur_cmd),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .out_free_i     (out_free),
    .res_load_o     (res_load),
    .res_cell_o     (res_cell)
  );

  // Output register.
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_row_q  <= cur_stat.row;
      out_col_q  <= cur_stat.col;
      out_cell_q <= res_cell;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_cell_q, out_col_q, out_row_q};

endmodule

FILE: dv/tb_text_console_writer_unit.sv
`timescale 1ns / 1ps

module tb_text_console_writer_unit;

  // Action code with no operation behind it.
  localparam logic [ctw_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 10;

  // One result as the console reports it.
  typedef struct packed {
    logic [ctw_pkg::ROW_W-1:0]   row;
    logic [ctw_pkg::COL_W-1:0]   col;
    logic [ctw_pkg::CHAR_W-1:0]  ch;
    logic [ctw_pkg::COLOR_W-1:0] attr;
  } console_result_t;

  // Screen model plus the queue of results still owed by the block.
  class console_scoreboard;
    logic [ctw_pkg::CELL_W-1:0]  cells [ctw_pkg::CELLS];
    int unsigned                 cursor;
    logic [ctw_pkg::COLOR_W-1:0] default_color;
    console_result_t             expected_q [$];
    int                          errors;

    function new();
      foreach (cells[i]) cells[i] = '0;
      cursor        = 0;
      default_color = ctw_pkg::DEFAULT_COLOR_RST;
      errors        = 0;
    endfunction

    function void set_default_color(input logic [ctw_pkg::COLOR_W-1:0] value);
      default_color = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Apply one accepted item to the screen and queue the result it owes.
    function void note_item(input ctw_pkg::item_t it);
      logic [ctw_pkg::COLOR_W-1:0] attr;
      logic [ctw_pkg::CELL_W-1:0]  cell_val;
      int unsigned                 next;
      console_result_t             res;
      cell_val = '0;
      unique case (it.action)
        ctw_pkg::ACT_PUT: begin
          attr = (it.color == '0) ? default_color : it.color;
          if (it.char_code == ctw_pkg::NEWLINE_CODE) begin
            next = (cursor / ctw_pkg::COLUMNS + 1) * ctw_pkg::COLUMNS;
          end else begin
            cells[cursor] = {attr, it.char_code};
            next = cursor + 1;
          end
          // Running off the last cell scrolls every row up by one.
          if (next >= ctw_pkg::CELLS) begin
            for (int i = 0; i < ctw_pkg::CELLS - ctw_pkg::COLUMNS; i++) begin
              cells[i] = cells[i + ctw_pkg::COLUMNS];
            end
            for (int i = ctw_pkg::CELLS - ctw_pkg::COLUMNS; i < ctw_pkg::CELLS; i++) begin
              cells[i] = '0;
            end
            next = ctw_pkg::CELLS - ctw_pkg::COLUMNS;
          end
          cursor = next;
        end
        ctw_pkg::ACT_CLEAR: begin
          foreach (cells[i]) cells[i] = {default_color, ctw_pkg::SPACE_CODE};
          cursor = 0;
        end
        ctw_pkg::ACT_READ: begin
          if (it.read_row < ctw_pkg::ROWS && it.read_col < ctw_pkg::COLUMNS) begin
            cell_val = cells[it.read_row * ctw_pkg::COLUMNS + it.read_col];
          end
        end
        default: begin
        end
      endcase
      res.row  = ctw_pkg::ROW_W'(cursor / ctw_pkg::COLUMNS);
      res.col  = ctw_pkg::COL_W'(cursor % ctw_pkg::COLUMNS);
      res.ch   = cell_val[ctw_pkg::CHAR_W-1:0];
      res.attr = cell_val[ctw_pkg::CELL_W-1:ctw_pkg::CHAR_W];
      expected_q.push_back(res);
    endfunction

    task report_mismatch(input string what, input int got, input int want);
      $display("ERROR at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
    endtask

    // Compare one delivered result against the oldest expectation.
    task check_result(input logic [31:0] data);
      console_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no item outstanding", int'(data), 0);
        return;
      end
      want = expected_q.pop_front();
      if (data[4:0] != want.row) begin
        report_mismatch("cursor_row", int'(data[4:0]), int'(want.row));
      end
      if (data[11:5] != want.col) begin
        report_mismatch("cursor_col", int'(data[11:5]), int'(want.col));
      end
      if (data[19:12] != want.ch) begin
        report_mismatch("cell_char", int'(data[19:12]), int'(want.ch));
      end
      if (data[27:20] != want.attr) begin
        report_mismatch("cell_color", int'(data[27:20]), int'(want.attr));
      end
    endtask

    task final_check();
      if (expected_q.size() != 0) begin
        report_mismatch("results never delivered", 0, expected_q.size());
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = '0;

  console_scoreboard sb = new();

  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int idle_cycles   = 0;

  text_console_writer_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Result side: check each delivered item, then decide the next tready.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Count cycles in which no channel moves anything.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic ctw_pkg::item_t make_item(input logic [ctw_pkg::ACT_W-1:0] action,
                                               input logic [ctw_pkg::CHAR_W-1:0] ch,
                                               input logic [ctw_pkg::COLOR_W-1:0] color,
                                               input logic [ctw_pkg::ROW_W-1:0] row,
                                               input logic [ctw_pkg::COL_W-1:0] col);
    ctw_pkg::item_t it;
    it.action    = action;
    it.char_code = ch;
    it.color     = color;
    it.read_row  = row;
    it.read_col  = col;
    return it;
  endfunction

  // Offer one item, wait for the handshake, then maybe go idle for a while.
  task automatic send_item(input ctw_pkg::item_t it);
    s_axis_tdata  <= {2'b00, it.read_col, it.read_row, it.color, it.char_code, it.action};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(it);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  // Stop offering items and wait until every owed result has arrived.
  task automatic stop_and_drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_default_color(input logic [ctw_pkg::COLOR_W-1:0] value);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_default_color(value);
  endtask

  // Mostly characters with random content, some reads and newlines, rare clears and unused actions.
  task automatic run_random(input int count, input int tx_idle, input int rx_stall);
    int             sent;
    int             burst;
    int             pick;
    ctw_pkg::item_t it;
    tx_idle_pct  = tx_idle;
    rx_stall_pct = rx_stall;
    sent = 0;
    while (sent < count) begin
      // A run of newlines pushes the cursor down and can reach the bottom row and scroll.
      if ($urandom_range(99) == 0) begin
        burst = $urandom_range(5, 25);
        repeat (burst) begin
          send_item(make_item(ctw_pkg::ACT_PUT, ctw_pkg::NEWLINE_CODE, 8'($urandom),
                              5'($urandom), 7'($urandom)));
        end
        sent += burst;
      end else begin
        pick = $urandom_range(999);
        it = make_item(ctw_pkg::ACT_PUT, 8'($urandom),
                       ($urandom_range(4) == 0) ? 8'h00 : 8'($urandom),
                       5'($urandom), 7'($urandom));
        if (pick >= 700 && pick < 760) begin
          it.char_code = ctw_pkg::NEWLINE_CODE;
        end else if (pick >= 760 && pick < 765) begin
          it.action = ctw_pkg::ACT_CLEAR;
        end else if (pick >= 765 && pick < 950) begin
          it.action = ctw_pkg::ACT_READ;
          // Most reads land on the screen; the rest use the whole field range.
          if ($urandom_range(6) != 0) begin
            it.read_row = 5'($urandom_range(ctw_pkg::ROWS - 1));
            it.read_col = 7'($urandom_range(ctw_pkg::COLUMNS - 1));
          end
        end else if (pick >= 950) begin
          it.action = ACT_UNUSED;
        end
        send_item(it);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed items under the reset default color.
    send_item(make_item(ctw_pkg::ACT_READ, 8'h00, 8'h00, 5'd0, 7'd0));
    send_item(make_item(ctw_pkg::ACT_PUT, 8'h41, 8'h00, 5'd0, 7'd0));
    send_item(make_item(ctw_pkg::ACT_PUT, 8'h00, 8'hFF, 5'd0, 7'd0));
    send_item(make_item(ctw_pkg::ACT_PUT, 8'hFF, 8'h01, 5'd0, 7'd0));
    send_item(make_item(ctw_pkg::ACT_READ, 8'h00, 8'h00, 5'd0, 7'd0));
    send_item(make_item(ctw_pkg::ACT_READ, 8'h00, 8'h00, 5'd0, 7'd1));
    send_item(make_item(ctw_pkg::ACT_READ, 8'h00, 8'h00, 5'd0, 7'd2));
    send_item(make_item(ctw_pkg::ACT_PUT, ctw_pkg::NEWLINE_CODE, 8'h00, 5'd0, 7'd0));
    send_item(make_item(ctw_pkg::ACT_PUT, 8'h7E, 8'hAA, 5'd31, 7'd127));
    send_item(make_item(ctw_pkg::ACT_READ, 8'hFF, 8'hFF, 5'd24, 7'd79));
    send_item(make_item(ctw_pkg::ACT_READ, 8'h00, 8'h00, 5'd25, 7'd0));
    send_item(make_item(ctw_pkg::ACT_READ, 8'h00, 8'h00, 5'd31, 7'd127));
    send_item(make_item(ctw_pkg::ACT_READ, 8'h00, 8'h00, 5'd0, 7'd80));
    send_item(make_item(ctw_pkg::ACT_READ, 8'h00, 8'h00, 5'd1, 7'd0));
    send_item(make_item(ACT_UNUSED, 8'h55, 8'hAA, 5'd3, 7'd4));
    send_item(make_item(ctw_pkg::ACT_CLEAR, 8'hFF, 8'hFF, 5'd31, 7'd127));
    send_item(make_item(ctw_pkg::ACT_READ, 8'h00, 8'h00, 5'd24, 7'd79));
    send_item(make_item(ctw_pkg::ACT_READ, 8'h00, 8'h00, 5'd0, 7'd0));
    send_item(make_item(ctw_pkg::ACT_PUT, ctw_pkg::SPACE_CODE, 8'h00, 5'd0, 7'd0));
    send_item(make_item(ctw_pkg::ACT_READ, 8'h00, 8'h00, 5'd0, 7'd0));

    // Random phases, each under its own default color and idling pattern.
    stop_and_drain();
    write_default_color(8'h00);
    run_random(300, 0, 0);
    stop_and_drain();
    write_default_color(8'hFF);
    run_random(300, 72, 0);
    stop_and_drain();
    write_default_color(8'($urandom_range(1, 254)));
    run_random(300, 0, 72);
    stop_and_drain();
    write_default_color(8'($urandom));
    run_random(300, 15, 15);

    // Back-pressure: the receiver holds off while items keep coming.
    stop_and_drain();
    hold_requests++;
    run_random(40, 0, 0);

    stop_and_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    sb.final_check();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
